// ----- design/dq_pkg.sv -----
`default_nettype none

package dq_pkg;

  // Queue geometry
  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // Operation codes carried by the kind field
  typedef enum logic [1:0] {
    KIND_PUSH_BACK  = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_POP_BACK   = 2'd2,
    KIND_POP_FRONT  = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_POP_EMPTY = 2'd1,
    STAT_PUSH_FULL = 2'd2
  } op_status_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_REPLY
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic exec;     // update indices, count, store
    logic load;     // refresh front/back value registers
  } cmd_t;

  // Circular index helpers
  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    idx_next = (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    idx_prev = (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
  endfunction

endpackage

`default_nettype wire

// ----- design/double_ended_queue.sv -----
// Bounded double-ended queue of signed 32-bit values in a 64-slot ring.
// An accepted start passes through states EXEC and LOAD, and done strobes in REPLY.
// Each item runs capture, update/store access, end-value refresh and result in
// turn; a new item is taken only once the last one's result has been shown.
// Reset (rst, synchronous): queue empty, both indices zero, busy low.
// Results show for one cycle on done; the receiver cannot stall them.
`default_nettype none

module double_ended_queue (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        kind,
  input  wire logic signed [dq_pkg::DATA_W-1:0]  push_value,
  output logic                                   done,
  output logic signed [dq_pkg::DATA_W-1:0]       front_value,
  output logic signed [dq_pkg::DATA_W-1:0]       back_value,
  output logic [dq_pkg::CNT_W-1:0]               entry_count,
  output logic                                   is_empty,
  output logic [1:0]                             status
);

  dq_pkg::cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  dq_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .kind        (kind),
    .push_value  (push_value),
    .front_value (front_value),
    .back_value  (back_value),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .status      (status)
  );

endmodule

`default_nettype wire

// ----- design/dq_ctrl.sv -----
`default_nettype none

module dq_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output dq_pkg::cmd_t      cmd,
  output logic              busy,
  output logic              done
);

  dq_pkg::state_t state;
  dq_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dq_pkg::ST_IDLE:  if (start) state_next = dq_pkg::ST_EXEC;
      dq_pkg::ST_EXEC:  state_next = dq_pkg::ST_LOAD;
      dq_pkg::ST_LOAD:  state_next = dq_pkg::ST_REPLY;
      dq_pkg::ST_REPLY: state_next = dq_pkg::ST_IDLE;
      default:          state_next = dq_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      dq_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      dq_pkg::ST_EXEC:  cmd.exec = 1'b1;
      dq_pkg::ST_LOAD:  cmd.load = 1'b1;
      dq_pkg::ST_REPLY: done = 1'b1;
      default:          busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/dq_datapath.sv -----
`default_nettype none

module dq_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire dq_pkg::cmd_t                         cmd,
  input  wire logic [1:0]                           kind,
  input  wire logic signed [dq_pkg::DATA_W-1:0]     push_value,
  output logic signed [dq_pkg::DATA_W-1:0]          front_value,
  output logic signed [dq_pkg::DATA_W-1:0]          back_value,
  output logic [dq_pkg::CNT_W-1:0]                  entry_count,
  output logic                                      is_empty,
  output logic [1:0]                                status
);

  // Slot store, one write and one registered read per cycle
  logic [dq_pkg::DATA_W-1:0] mem [dq_pkg::DEPTH];
  logic [dq_pkg::DATA_W-1:0] rd_data;

  // Latched item
  dq_pkg::kind_t             kind_q;
  logic [dq_pkg::DATA_W-1:0] value_q;

  // Queue control state
  logic [dq_pkg::IDX_W-1:0]  front_index;
  logic [dq_pkg::IDX_W-1:0]  back_index;
  logic [dq_pkg::CNT_W-1:0]  stored_count;

  // Per-item result bookkeeping
  dq_pkg::op_status_t        status_q;
  logic                      was_empty;
  logic [dq_pkg::DATA_W-1:0] front_cache;
  logic [dq_pkg::DATA_W-1:0] back_cache;

  logic                      is_push;
  logic                      q_full;
  logic                      q_empty;
  logic                      do_write;
  logic [dq_pkg::IDX_W-1:0]  wr_addr;
  logic [dq_pkg::IDX_W-1:0]  rd_addr;

  assign is_push  = (kind_q == dq_pkg::KIND_PUSH_BACK) ||
                    (kind_q == dq_pkg::KIND_PUSH_FRONT);
  assign q_full   = (stored_count == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign q_empty  = (stored_count == '0);
  assign do_write = cmd.exec && is_push && !q_full;

  // Slot addresses: where a push lands, and the new end after a pop
  always_comb begin
    if (q_empty) begin
      wr_addr = front_index;
    end else if (kind_q == dq_pkg::KIND_PUSH_BACK) begin
      wr_addr = dq_pkg::idx_next(back_index);
    end else begin
      wr_addr = dq_pkg::idx_prev(front_index);
    end
    if (kind_q == dq_pkg::KIND_POP_BACK) begin
      rd_addr = dq_pkg::idx_prev(back_index);
    end else begin
      rd_addr = dq_pkg::idx_next(front_index);
    end
  end

  // Store write and read
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_addr] <= value_q;
    end
    rd_data <= mem[rd_addr];
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q  <= dq_pkg::kind_t'(kind);
      value_q <= push_value;
    end
  end

  // Index and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      front_index  <= '0;
      back_index   <= '0;
      stored_count <= '0;
      status_q     <= dq_pkg::STAT_DONE;
      was_empty    <= 1'b1;
    end else if (cmd.exec) begin
      was_empty <= q_empty;
      if (is_push) begin
        if (q_full) begin
          status_q <= dq_pkg::STAT_PUSH_FULL;
        end else begin
          status_q     <= dq_pkg::STAT_DONE;
          stored_count <= stored_count + dq_pkg::CNT_W'(1);
          if (q_empty) begin
            back_index <= front_index;
          end else if (kind_q == dq_pkg::KIND_PUSH_BACK) begin
            back_index <= wr_addr;
          end else begin
            front_index <= wr_addr;
          end
        end
      end else begin
        if (q_empty) begin
          status_q <= dq_pkg::STAT_POP_EMPTY;
        end else begin
          status_q     <= dq_pkg::STAT_DONE;
          stored_count <= stored_count - dq_pkg::CNT_W'(1);
          // last entry leaves the indices in place
          if (stored_count > dq_pkg::CNT_W'(1)) begin
            if (kind_q == dq_pkg::KIND_POP_BACK) begin
              back_index <= rd_addr;
            end else begin
              front_index <= rd_addr;
            end
          end
        end
      end
    end
  end

  // End values held in registers; a pop refetches the new end
  always_ff @(posedge clk) begin
    if (cmd.load && (status_q == dq_pkg::STAT_DONE)) begin
      unique case (kind_q)
        dq_pkg::KIND_PUSH_BACK: begin
          back_cache <= value_q;
          if (was_empty) front_cache <= value_q;
        end
        dq_pkg::KIND_PUSH_FRONT: begin
          front_cache <= value_q;
          if (was_empty) back_cache <= value_q;
        end
        dq_pkg::KIND_POP_BACK:  back_cache  <= rd_data;
        dq_pkg::KIND_POP_FRONT: front_cache <= rd_data;
        default: ;
      endcase
    end
  end

  // Result ports; values read as zero when empty
  assign is_empty    = q_empty;
  assign entry_count = stored_count;
  assign front_value = q_empty ? '0 : front_cache;
  assign back_value  = q_empty ? '0 : back_cache;
  assign status      = status_q;

endmodule

`default_nettype wire

// ----- design/dq_checker.sv -----
`default_nettype none

module dq_props (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              done,
  input wire logic signed [dq_pkg::DATA_W-1:0]  front_value,
  input wire logic signed [dq_pkg::DATA_W-1:0]  back_value,
  input wire logic [dq_pkg::CNT_W-1:0]          entry_count,
  input wire logic                              is_empty,
  input wire logic [1:0]                        status
);

  // accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted item");

  // a result is only ever shown while an item is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done without busy");

  // empty flag agrees with count, values zero when empty
  a_empty: assert property (@(posedge clk) disable iff (rst)
    done |-> ((is_empty == (entry_count == '0)) &&
              (!is_empty || ((front_value == '0) && (back_value == '0)))))
    else $error("empty result inconsistent");

  // dropped push only when full, failed pop only when empty
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> ((status != dq_pkg::STAT_PUSH_FULL ||
               entry_count == dq_pkg::CNT_W'(dq_pkg::DEPTH)) &&
              (status != dq_pkg::STAT_POP_EMPTY || is_empty)))
    else $error("status disagrees with count");

  // count never exceeds depth
  a_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (entry_count <= dq_pkg::CNT_W'(dq_pkg::DEPTH)))
    else $error("count over depth");

endmodule

bind double_ended_queue dq_props u_dq_props (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .front_value (front_value),
  .back_value  (back_value),
  .entry_count (entry_count),
  .is_empty    (is_empty),
  .status      (status)
);

`default_nettype wire

// ----- sim/dq_checker.sv -----
`timescale 1ns / 1ps

// Watches the command and result sides of the deque, keeps its own copy of
// the ring, and compares every result with the one it predicts.
module dq_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic                             busy,
  input  wire logic [1:0]                       kind,
  input  wire logic signed [dq_pkg::DATA_W-1:0] push_value,
  input  wire logic                             done,
  input  wire logic signed [dq_pkg::DATA_W-1:0] front_value,
  input  wire logic signed [dq_pkg::DATA_W-1:0] back_value,
  input  wire logic [dq_pkg::CNT_W-1:0]         entry_count,
  input  wire logic                             is_empty,
  input  wire logic [1:0]                       status,
  output int                                    mismatch_count,
  output int                                    results_owed
);

  typedef struct {
    logic [dq_pkg::DATA_W-1:0] front;
    logic [dq_pkg::DATA_W-1:0] back;
    logic [dq_pkg::CNT_W-1:0]  count;
    logic                      empty;
    dq_pkg::op_status_t        stat;
  } dq_view_t;

  // Shadow copy of the deque
  logic [dq_pkg::DATA_W-1:0] ring [dq_pkg::DEPTH];
  logic [dq_pkg::IDX_W-1:0]  head_idx;
  logic [dq_pkg::IDX_W-1:0]  tail_idx;
  logic [dq_pkg::CNT_W-1:0]  level;

  dq_view_t owed_views [$];

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
  end

  function automatic logic [dq_pkg::IDX_W-1:0] step_up(input logic [dq_pkg::IDX_W-1:0] i);
    return (i == dq_pkg::IDX_W'(dq_pkg::DEPTH - 1)) ? '0 : i + dq_pkg::IDX_W'(1);
  endfunction

  function automatic logic [dq_pkg::IDX_W-1:0] step_down(input logic [dq_pkg::IDX_W-1:0] i);
    return (i == '0) ? dq_pkg::IDX_W'(dq_pkg::DEPTH - 1) : i - dq_pkg::IDX_W'(1);
  endfunction

  // Apply one operation to the shadow deque and return what it should report
  function automatic dq_view_t apply_op(input dq_pkg::kind_t op,
                                        input logic [dq_pkg::DATA_W-1:0] val);
    dq_view_t v;
    v.stat = dq_pkg::STAT_DONE;
    if (op == dq_pkg::KIND_PUSH_BACK || op == dq_pkg::KIND_PUSH_FRONT) begin
      if (level >= dq_pkg::CNT_W'(dq_pkg::DEPTH)) begin
        v.stat = dq_pkg::STAT_PUSH_FULL;
      end else begin
        // first entry goes where the front index already points
        if (level == '0) tail_idx = head_idx;
        else if (op == dq_pkg::KIND_PUSH_BACK) tail_idx = step_up(tail_idx);
        else head_idx = step_down(head_idx);
        ring[(op == dq_pkg::KIND_PUSH_BACK) ? tail_idx : head_idx] = val;
        level = level + dq_pkg::CNT_W'(1);
      end
    end else begin
      if (level == '0) begin
        v.stat = dq_pkg::STAT_POP_EMPTY;
      end else begin
        // popping the last entry leaves both indices in place
        if (level > dq_pkg::CNT_W'(1)) begin
          if (op == dq_pkg::KIND_POP_BACK) tail_idx = step_down(tail_idx);
          else head_idx = step_up(head_idx);
        end
        level = level - dq_pkg::CNT_W'(1);
      end
    end
    v.count = level;
    v.empty = (level == '0);
    v.front = v.empty ? '0 : ring[head_idx];
    v.back  = v.empty ? '0 : ring[tail_idx];
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] deque check: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    dq_view_t want;
    if (rst) begin
      owed_views.delete();
      head_idx = '0;
      tail_idx = '0;
      level    = '0;
    end else begin
      // results first: a result at this edge belongs to an earlier item
      if (done) begin
        if (owed_views.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = owed_views[0];
          owed_views.delete(0);
          if (front_value !== want.front)
            report_mismatch($sformatf("front_value %h, expected %h", front_value, want.front));
          if (back_value !== want.back)
            report_mismatch($sformatf("back_value %h, expected %h", back_value, want.back));
          if (entry_count !== want.count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      entry_count, want.count));
          if (is_empty !== want.empty)
            report_mismatch($sformatf("is_empty %b, expected %b", is_empty, want.empty));
          if (status !== want.stat)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.stat));
        end
      end
      // accepted item
      if (start && !busy)
        owed_views.insert(owed_views.size(), apply_op(dq_pkg::kind_t'(kind), push_value));
    end
    results_owed = owed_views.size();
  end

endmodule

// ----- sim/double_ended_queue_test.sv -----
`timescale 1ns / 1ps

module double_ended_queue_test;

  localparam int RANDOM_ITEMS = 1000;
  localparam int STALL_LIMIT  = 1000;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic [1:0]                       kind = dq_pkg::KIND_PUSH_BACK;
  logic signed [dq_pkg::DATA_W-1:0] push_value = '0;

  wire logic                             busy;
  wire logic                             done;
  wire logic signed [dq_pkg::DATA_W-1:0] front_value;
  wire logic signed [dq_pkg::DATA_W-1:0] back_value;
  wire logic [dq_pkg::CNT_W-1:0]         entry_count;
  wire logic                             is_empty;
  wire logic [1:0]                       status;

  int mismatch_count;
  int results_owed;
  int stall_cycles = 0;
  bit quiet = 1'b0;

  double_ended_queue dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .push_value(push_value), .done(done), .front_value(front_value),
    .back_value(back_value), .entry_count(entry_count), .is_empty(is_empty),
    .status(status)
  );

  dq_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .push_value(push_value), .done(done), .front_value(front_value),
    .back_value(back_value), .entry_count(entry_count), .is_empty(is_empty),
    .status(status), .mismatch_count(mismatch_count), .results_owed(results_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: ends the run if neither side moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Present one item and hold it until the edge that takes it
  task automatic issue(input dq_pkg::kind_t op, input logic [dq_pkg::DATA_W-1:0] val);
    start      <= 1'b1;
    kind       <= op;
    push_value <= val;
    do @(posedge clk); while (busy);
  endtask

  // Random gap between items, skipped during the quiet stretch
  task automatic maybe_idle();
    if (!quiet && $urandom_range(99) < 31) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  function automatic logic [dq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic dq_pkg::kind_t pick_kind(input int push_pct);
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? dq_pkg::KIND_PUSH_BACK : dq_pkg::KIND_PUSH_FRONT;
    return $urandom_range(1) ? dq_pkg::KIND_POP_BACK : dq_pkg::KIND_POP_FRONT;
  endfunction

  initial begin
    int sent;
    int phase_len;
    int push_pct;
    int phase_no;
    bit paused;

    sent = 0;
    phase_no = 0;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: pops on empty, extremes, last-entry pops, both ends
    issue(dq_pkg::KIND_POP_BACK, 32'h1234_5678);
    issue(dq_pkg::KIND_POP_FRONT, 32'h0);
    issue(dq_pkg::KIND_PUSH_BACK, 32'h8000_0000);
    issue(dq_pkg::KIND_PUSH_FRONT, 32'h7fff_ffff);
    issue(dq_pkg::KIND_POP_BACK, 32'hffff_ffff);
    issue(dq_pkg::KIND_POP_FRONT, 32'h0);
    issue(dq_pkg::KIND_POP_FRONT, 32'h0);
    issue(dq_pkg::KIND_PUSH_FRONT, 32'h0);
    issue(dq_pkg::KIND_PUSH_BACK, 32'hffff_ffff);
    issue(dq_pkg::KIND_PUSH_BACK, 32'haaaa_aaaa);
    issue(dq_pkg::KIND_PUSH_FRONT, 32'h5555_5555);
    issue(dq_pkg::KIND_POP_FRONT, 32'h0);
    issue(dq_pkg::KIND_POP_BACK, 32'h0);
    issue(dq_pkg::KIND_POP_BACK, 32'h0);
    issue(dq_pkg::KIND_POP_BACK, 32'h0);
    issue(dq_pkg::KIND_POP_BACK, 32'h0);

    // Random phases: fill past full, drain past empty, then mixed levels
    while (sent < RANDOM_ITEMS) begin
      case (phase_no)
        0: push_pct = 100;
        1: push_pct = 0;
        default: begin
          case ($urandom_range(4))
            0: push_pct = 100;
            1: push_pct = 0;
            2: push_pct = 75;
            3: push_pct = 25;
            default: push_pct = 50;
          endcase
        end
      endcase
      phase_len = (push_pct == 100 || push_pct == 0) ? 72 : $urandom_range(20, 80);
      phase_no++;
      repeat (phase_len) begin
        quiet = (sent >= 300 && sent < 450);
        issue(pick_kind(push_pct), pick_value());
        sent++;
        // hold off once until every owed result is back
        if (!paused && sent >= 500) begin
          paused = 1'b1;
          drain_results();
        end else begin
          maybe_idle();
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
